>>> design/aws_pkg.sv
`default_nettype none

package aws_pkg;

    localparam int AVERAGE_SAMPLES = 120;
    localparam int GUST_SLOTS      = 10;
    localparam int TICKS_PER_SLOT  = 60;

    localparam int RING_AW   = $clog2(AVERAGE_SAMPLES);
    localparam int SLOT_AW   = (GUST_SLOTS > 1) ? $clog2(GUST_SLOTS) : 1;
    localparam int SEC_W     = (TICKS_PER_SLOT > 1) ? $clog2(TICKS_PER_SLOT) : 1;
    localparam int SUM_W     = $clog2(AVERAGE_SAMPLES * 255 + 1);
    localparam int AVG_XW    = SUM_W + 8;
    localparam int AVG_RECIP = (2 ** AVG_XW) / AVERAGE_SAMPLES;
    localparam int RECIP_W   = $clog2(AVG_RECIP + 1);
    localparam int AVG_PW    = AVG_XW + RECIP_W;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 1'd1;

    localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
    localparam logic [15:0] GAIN_RESET     = 16'd1492;
    localparam logic [15:0] SPEED_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_EDGE    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [15:0] current_speed;
        logic [15:0] average_speed;
        logic [15:0] window_gust;
        logic [15:0] overall_gust;
    } out_item_t;

    typedef struct packed {
        logic [15:0] clicks;
        logic [31:0] elapsed;
    } tick_cmd_t;

endpackage

`default_nettype wire

>>> design/anemometer_wind_statistics.sv
// From the accepting edge to the result on the ports, a tick passes the command
// queue, the speed unit (multiply, range check and, unless that settles it, a
// 16-step divide) and the ring/average update, gust update, ten-slot scan and
// output. Ticks are worked on one at a time, the next once the last result sits
// in the output register. Up to two ticks queue behind the one in progress.
// Reset (rst_n low, asynchronous) clears all state; the sample ring reads as
// zero through per-entry valid bits, so no clearing pass follows reset.
`default_nettype none

module anemometer_wind_statistics (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire aws_pkg::in_item_t              item,
    output logic                                empty,
    input  wire logic                           pop,
    output aws_pkg::out_item_t                  result,
    input  wire logic                           cfg_write,
    input  wire logic [aws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aws_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aws_pkg::*;

    logic        cmd_push;
    logic        cmd_full;
    logic        cmd_pop;
    logic        cmd_empty;
    tick_cmd_t   cmd_wr;
    tick_cmd_t   cmd_rd;
    logic [15:0] gain;

    aws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gain      (gain),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_wr),
        .cmd_full  (cmd_full)
    );

    aws_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    aws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rd),
        .cmd_pop   (cmd_pop),
        .gain      (gain),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> design/aws_front.sv
`default_nettype none

module aws_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire aws_pkg::in_item_t              item,
    input  wire logic                           cfg_write,
    input  wire logic [aws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aws_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [15:0]                         gain,
    output logic                                cmd_push,
    output aws_pkg::tick_cmd_t                  cmd_data,
    input  wire logic                           cmd_full
);
    import aws_pkg::*;

    logic [7:0]  debounce_reg, debounce_next;
    logic [15:0] gain_reg, gain_next;
    logic [15:0] clicks_reg, clicks_next;
    logic [31:0] last_edge_reg, last_edge_next;
    logic [31:0] last_sample_reg, last_sample_next;
    logic        accept;
    logic [31:0] since_edge;

    assign full       = cmd_full;
    assign accept     = push && !cmd_full;
    assign since_edge = item.time_ms - last_edge_reg;
    assign gain       = gain_reg;

    assign cmd_push = accept && (item.action == ACT_TICK);
    assign cmd_data = '{clicks: clicks_reg, elapsed: item.time_ms - last_sample_reg};

    always_comb
    begin
        debounce_next    = debounce_reg;
        gain_next        = gain_reg;
        clicks_next      = clicks_reg;
        last_edge_next   = last_edge_reg;
        last_sample_next = last_sample_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_next = cfg_data[7:0];
                REG_GAIN:     gain_next     = cfg_data[15:0];
                default:      ;
            endcase
        end

        if (accept)
        begin
            unique case (item.action)
                ACT_EDGE:
                begin
                    if (since_edge > {24'd0, debounce_reg})
                    begin
                        last_edge_next = item.time_ms;
                        if (clicks_reg != SPEED_MAX)
                        begin
                            clicks_next = clicks_reg + 16'd1;
                        end
                    end
                end
                ACT_TICK, ACT_RESTART:
                begin
                    clicks_next      = '0;
                    last_sample_next = item.time_ms;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RESET;
            gain_reg        <= GAIN_RESET;
            clicks_reg      <= '0;
            last_edge_reg   <= '0;
            last_sample_reg <= '0;
        end
        else
        begin
            debounce_reg    <= debounce_next;
            gain_reg        <= gain_next;
            clicks_reg      <= clicks_next;
            last_edge_reg   <= last_edge_next;
            last_sample_reg <= last_sample_next;
        end
    end

endmodule

`default_nettype wire

>>> design/aws_cmd_fifo.sv
`default_nettype none

module aws_cmd_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire aws_pkg::tick_cmd_t wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output aws_pkg::tick_cmd_t      rd_data,
    output logic                    empty
);
    import aws_pkg::*;

    localparam int PTR_W = (CMD_AW > 0) ? CMD_AW : 1;

    tick_cmd_t          entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMD_AW:0]    count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == (CMD_AW + 1)'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/aws_speed.sv
`default_nettype none

module aws_speed (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire aws_pkg::tick_cmd_t cmd,
    input  wire logic [15:0]        gain,
    output logic                    done,
    output logic [15:0]             speed
);
    import aws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_DIV
    } state_t;

    state_t             state_reg;
    logic [15:0]        clicks_reg;
    logic [31:0]        elapsed_reg;
    logic [31:0]        prod_reg;
    logic [31:0]        rem_reg;
    logic [15:0]        num_lo_reg;
    logic [15:0]        quot_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [15:0]        speed_reg;
    logic               done_reg;

    logic [32:0]        trial;
    logic               trial_ge;
    logic [31:0]        rem_step;
    logic               saturate;

    assign trial    = {rem_reg, num_lo_reg[15]};
    assign trial_ge = (trial >= {1'b0, elapsed_reg});
    assign rem_step = trial_ge ? 32'(trial - {1'b0, elapsed_reg}) : trial[31:0];
    assign saturate = ({8'd0, prod_reg[31:8]} >= elapsed_reg);

    assign done  = done_reg;
    assign speed = speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            speed_reg   <= '0;
            clicks_reg  <= '0;
            elapsed_reg <= '0;
            prod_reg    <= '0;
            rem_reg     <= '0;
            num_lo_reg  <= '0;
            quot_reg    <= '0;
            step_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        clicks_reg  <= cmd.clicks;
                        elapsed_reg <= cmd.elapsed;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= clicks_reg * gain;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (elapsed_reg == '0)
                    begin
                        speed_reg <= (clicks_reg != '0) ? SPEED_MAX : '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (saturate)
                    begin
                        speed_reg <= SPEED_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        rem_reg    <= {8'd0, prod_reg[31:8]};
                        num_lo_reg <= {prod_reg[7:0], 8'd0};
                        quot_reg   <= '0;
                        step_reg   <= '0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg    <= rem_step;
                    num_lo_reg <= {num_lo_reg[14:0], 1'b0};
                    quot_reg   <= {quot_reg[14:0], trial_ge};
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        speed_reg <= {quot_reg[14:0], trial_ge};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/aws_back.sv
`default_nettype none

module aws_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_empty,
    input  wire aws_pkg::tick_cmd_t cmd_data,
    output logic                    cmd_pop,
    input  wire logic [15:0]        gain,
    input  wire logic               pop,
    output logic                    empty,
    output aws_pkg::out_item_t      result
);
    import aws_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WAIT,
        B_RING,
        B_UPDATE,
        B_ROLL,
        B_SCAN,
        B_OUT
    } state_t;

    state_t                      state_reg;
    logic [15:0]                 speed_reg;
    logic [RING_AW-1:0]          ring_pos_reg;
    logic [SUM_W-1:0]            ring_sum_reg;
    logic [7:0]                  ring_mem [AVERAGE_SAMPLES];
    logic [7:0]                  ring_rd_reg;
    logic [AVERAGE_SAMPLES-1:0]  ring_vld_reg;
    logic                        ring_vld_rd_reg;
    logic [15:0]                 gust_reg [GUST_SLOTS];
    logic [SLOT_AW-1:0]          slot_pos_reg;
    logic [SEC_W-1:0]            sec_reg;
    logic [SLOT_AW-1:0]          scan_reg;
    logic [15:0]                 window_reg;
    logic [15:0]                 all_gust_reg;
    logic [AVG_PW-1:0]           avg_prod_reg;
    logic [15:0]                 avg_reg;
    logic                        out_valid_reg;
    out_item_t                   out_reg;

    logic [RING_AW-1:0]          ring_ra;
    logic                        ring_we;
    logic [7:0]                  old_sample;
    logic [SLOT_AW-1:0]          gust_idx;
    logic [15:0]                 gust_rd;
    logic [SLOT_AW-1:0]          slot_step;
    logic [SEC_W:0]              sec_inc;
    logic [AVG_XW-1:0]           avg_x;
    logic [RECIP_W-1:0]          avg_q0;
    logic [AVG_XW-1:0]           avg_nq;
    logic [AVG_XW-1:0]           avg_rem;
    logic [RECIP_W-1:0]          avg_q;
    logic                        spd_start;
    logic                        spd_done;
    logic [15:0]                 spd_val;

    assign ring_ra = (ring_pos_reg == RING_AW'(AVERAGE_SAMPLES - 1)) ? '0
                                                                     : ring_pos_reg + 1'b1;
    assign ring_we    = (state_reg == B_RING);
    assign old_sample = ring_vld_rd_reg ? ring_rd_reg : 8'd0;

    assign gust_idx  = (state_reg == B_SCAN) ? scan_reg : slot_pos_reg;
    assign gust_rd   = gust_reg[gust_idx];
    assign slot_step = (slot_pos_reg == SLOT_AW'(GUST_SLOTS - 1)) ? '0 : slot_pos_reg + 1'b1;
    assign sec_inc   = {1'b0, sec_reg} + 1'b1;

    assign avg_x   = {ring_sum_reg, 8'd0};
    assign avg_q0  = avg_prod_reg[AVG_PW-1:AVG_XW];
    assign avg_nq  = AVG_XW'(AVG_XW'(avg_q0) * AVG_XW'(AVERAGE_SAMPLES));
    assign avg_rem = avg_x - avg_nq;
    assign avg_q   = (avg_rem >= AVG_XW'(AVERAGE_SAMPLES)) ? avg_q0 + 1'b1 : avg_q0;

    assign spd_start = (state_reg == B_IDLE) && !cmd_empty;
    assign cmd_pop   = spd_start;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    aws_speed u_speed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (spd_start),
        .cmd   (cmd_data),
        .gain  (gain),
        .done  (spd_done),
        .speed (spd_val)
    );

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_ra] <= speed_reg[15:8];
        end
        ring_rd_reg <= ring_mem[ring_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg    <= '0;
            ring_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (ring_we)
            begin
                ring_vld_reg[ring_ra] <= 1'b1;
            end
            ring_vld_rd_reg <= ring_vld_reg[ring_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            speed_reg     <= '0;
            ring_pos_reg  <= '0;
            ring_sum_reg  <= '0;
            for (int i = 0; i < GUST_SLOTS; i++)
            begin
                gust_reg[i] <= '0;
            end
            slot_pos_reg  <= '0;
            sec_reg       <= '0;
            scan_reg      <= '0;
            window_reg    <= '0;
            all_gust_reg  <= '0;
            avg_prod_reg  <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg && (state_reg != B_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        state_reg <= B_WAIT;
                    end
                end
                B_WAIT:
                begin
                    if (spd_done)
                    begin
                        speed_reg <= spd_val;
                        state_reg <= B_RING;
                    end
                end
                B_RING:
                begin
                    ring_sum_reg <= ring_sum_reg - SUM_W'(old_sample) + SUM_W'(speed_reg[15:8]);
                    ring_pos_reg <= ring_ra;
                    state_reg    <= B_UPDATE;
                end
                B_UPDATE:
                begin
                    avg_prod_reg <= AVG_PW'(avg_x) * AVG_PW'(AVG_RECIP);
                    if (speed_reg > gust_rd)
                    begin
                        gust_reg[slot_pos_reg] <= speed_reg;
                    end
                    if (speed_reg > all_gust_reg)
                    begin
                        all_gust_reg <= speed_reg;
                    end
                    state_reg <= B_ROLL;
                end
                B_ROLL:
                begin
                    avg_reg <= 16'(avg_q);
                    if (sec_inc == (SEC_W + 1)'(TICKS_PER_SLOT))
                    begin
                        sec_reg             <= '0;
                        slot_pos_reg        <= slot_step;
                        gust_reg[slot_step] <= '0;
                    end
                    else
                    begin
                        sec_reg <= sec_inc[SEC_W-1:0];
                    end
                    scan_reg   <= '0;
                    window_reg <= '0;
                    state_reg  <= B_SCAN;
                end
                B_SCAN:
                begin
                    if (gust_rd > window_reg)
                    begin
                        window_reg <= gust_rd;
                    end
                    if (scan_reg == SLOT_AW'(GUST_SLOTS - 1))
                    begin
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                B_OUT:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        out_reg       <= '{current_speed: speed_reg,
                                           average_speed: avg_reg,
                                           window_gust:   window_reg,
                                           overall_gust:  all_gust_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/aws_checker.sv
`default_nettype none

module aws_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire aws_pkg::out_item_t result
);
    import aws_pkg::*;

    property p_empty_in_reset;
        @(posedge clk) !rst_n |-> empty;
    endproperty

    property p_hold_result;
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result));
    endproperty

    property p_overall_covers_current;
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (result.overall_gust >= result.current_speed);
    endproperty

    property p_overall_covers_window;
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (result.overall_gust >= result.window_gust);
    endproperty

    a_empty_in_reset: assert property (p_empty_in_reset)
        else $error("result queue not empty during reset");
    a_hold_result: assert property (p_hold_result)
        else $error("waiting result changed or vanished");
    a_overall_current: assert property (p_overall_covers_current)
        else $error("overall gust below current speed");
    a_overall_window: assert property (p_overall_covers_window)
        else $error("overall gust below window gust");

endmodule

bind anemometer_wind_statistics aws_checker u_aws_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import aws_pkg::*;

    localparam int RUN_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    class wind_tracker;
        logic [7:0]  debounce;
        logic [15:0] gain;
        logic [15:0] clicks;
        logic [31:0] last_edge;
        logic [31:0] last_sample;
        logic [7:0]  ring [AVERAGE_SAMPLES];
        int          ring_pos;
        int          ring_sum;
        logic [15:0] slot_gust [GUST_SLOTS];
        int          slot_pos;
        int          second;
        logic [15:0] peak;
        out_item_t   reports [$];
        int          failures;

        function new();
            debounce    = DEBOUNCE_RESET;
            gain        = GAIN_RESET;
            clicks      = '0;
            last_edge   = '0;
            last_sample = '0;
            foreach (ring[i])
                ring[i] = '0;
            foreach (slot_gust[i])
                slot_gust[i] = '0;
            ring_pos = 0;
            ring_sum = 0;
            slot_pos = 0;
            second   = 0;
            peak     = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DEBOUNCE)
                debounce = val[7:0];
            else if (idx == REG_GAIN)
                gain = val;
        endfunction

        function void note_event(in_item_t beat);
            logic [31:0] now;
            logic [31:0] elapsed;
            logic [63:0] q;
            logic [15:0] speed;
            logic [15:0] window;
            out_item_t   rep;
            now = beat.time_ms;
            case (beat.action)
                ACT_EDGE:
                begin
                    if ((now - last_edge) > {24'd0, debounce})
                    begin
                        last_edge = now;
                        if (clicks != SPEED_MAX)
                            clicks = clicks + 16'd1;
                    end
                end
                ACT_RESTART:
                begin
                    clicks      = '0;
                    last_sample = now;
                end
                ACT_TICK:
                begin
                    elapsed = now - last_sample;
                    if (elapsed == 32'd0)
                        speed = (clicks == 16'd0) ? 16'd0 : SPEED_MAX;
                    else
                    begin
                        q = (64'(clicks) * 64'(gain) * 64'd256) / 64'(elapsed);
                        speed = (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[15:0];
                    end
                    clicks      = '0;
                    last_sample = now;

                    ring_pos = (ring_pos + 1) % AVERAGE_SAMPLES;
                    ring_sum = ring_sum - int'(ring[ring_pos]) + int'(speed[15:8]);
                    ring[ring_pos] = speed[15:8];

                    if (speed > slot_gust[slot_pos])
                        slot_gust[slot_pos] = speed;
                    if (speed > peak)
                        peak = speed;

                    second++;
                    if (second >= TICKS_PER_SLOT)
                    begin
                        second   = 0;
                        slot_pos = (slot_pos + 1) % GUST_SLOTS;
                        slot_gust[slot_pos] = '0;
                    end

                    window = '0;
                    foreach (slot_gust[i])
                        if (slot_gust[i] > window)
                            window = slot_gust[i];

                    rep.current_speed = speed;
                    rep.average_speed = 16'(ring_sum * 256 / AVERAGE_SAMPLES);
                    rep.window_gust   = window;
                    rep.overall_gust  = peak;
                    reports.push_back(rep);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (reports.size() == 0)
            begin
                $error("result with no expectation waiting: current_speed %0d",
                       got.current_speed);
                failures++;
                return;
            end
            want = reports.pop_front();
            compare_field("current_speed", want.current_speed, got.current_speed);
            compare_field("average_speed", want.average_speed, got.average_speed);
            compare_field("window_gust", want.window_gust, got.window_gust);
            compare_field("overall_gust", want.overall_gust, got.overall_gust);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n;
    logic                  push      = 1'b0;
    logic                  full;
    in_item_t              item      = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    out_item_t             result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          push_idle_pct = 0;
    int          pop_idle_pct  = 0;
    int          hold_request  = 0;
    int          cycle_count   = 0;
    logic [31:0] now_ms        = '0;
    wind_tracker tracker       = new();

    anemometer_wind_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                tracker.check_report(result);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= pop_idle_pct);
        end
    end

    task automatic send_event(input in_item_t beat);
        while ($urandom_range(0, 99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (full);
        tracker.note_event(beat);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (tracker.reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [7:0] deb, input logic [15:0] gain_val);
        logic [CFG_DATA_W-1:0] deb_word;
        deb_word = {8'($urandom), deb};
        cfg_write <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= deb_word;
        @(posedge clk);
        tracker.write_reg(REG_DEBOUNCE, deb_word);
        cfg_index <= REG_GAIN;
        cfg_data  <= gain_val;
        @(posedge clk);
        tracker.write_reg(REG_GAIN, gain_val);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] tick_gap();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 3);
            2:       return $urandom;
            default: return $urandom_range(900, 1100);
        endcase
    endfunction

    task automatic run_wind(input int budget, input bit squeeze);
        int         sent;
        int         n;
        logic [1:0] act;
        sent = 0;
        while (sent < budget)
        begin
            // hold off the reader so the block backs up
            if (squeeze && sent >= budget / 2)
            begin
                hold_request = HOLD_CYCLES;
                squeeze      = 1'b0;
            end
            case ($urandom_range(0, 99)) inside
                [0:69]:
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(0, 2);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 9))
                            0:       now_ms += tracker.debounce;
                            1:       now_ms += tracker.debounce + 1;
                            default: now_ms += $urandom_range(0, 2 * tracker.debounce + 2);
                        endcase
                        send_event('{ACT_EDGE, now_ms});
                    end
                    now_ms += tick_gap();
                    send_event('{ACT_TICK, now_ms});
                    sent += n + 1;
                end
                [70:84]:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                    begin
                        now_ms += tick_gap();
                        send_event('{ACT_TICK, now_ms});
                    end
                    sent += n;
                end
                [85:91]:
                begin
                    now_ms += $urandom_range(0, 1000);
                    send_event('{ACT_RESTART, now_ms});
                    sent++;
                end
                default:
                begin
                    act = 2'($urandom_range(0, 3));
                    send_event('{act, 32'($urandom)});
                    if (act != ACT_UNUSED)
                        sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        #1 rst_n <= 1'b0;
        push_idle_pct = 15;
        pop_idle_pct  = 78;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event('{ACT_EDGE, 32'd10});
        send_event('{ACT_EDGE, 32'd20});
        send_event('{ACT_EDGE, 32'd21});
        send_event('{ACT_EDGE, 32'd41});
        send_event('{ACT_EDGE, 32'd42});
        send_event('{ACT_UNUSED, 32'd43});
        send_event('{ACT_TICK, 32'd1000});
        send_event('{ACT_TICK, 32'd1000});
        send_event('{ACT_EDGE, 32'd1100});
        send_event('{ACT_TICK, 32'd1000});
        send_event('{ACT_RESTART, 32'd5000});
        send_event('{ACT_EDGE, 32'd5500});
        send_event('{ACT_RESTART, 32'd6000});
        send_event('{ACT_TICK, 32'd7000});
        send_event('{ACT_EDGE, 32'hFFFF_FFFF});
        send_event('{ACT_EDGE, 32'h0000_0014});
        send_event('{ACT_TICK, 32'h0000_03E8});
        send_event('{ACT_EDGE, 32'h0000_0010});
        send_event('{ACT_TICK, 32'h8000_0000});
        send_event('{ACT_UNUSED, 32'hFFFF_FFFF});
        send_event('{ACT_TICK, 32'h8000_0001});

        now_ms = $urandom;
        run_wind(350, 1'b1);
        wait_idle();
        program_registers(8'd0, 16'hFFFF);
        now_ms = 32'hFFFF_F000;
        run_wind(350, 1'b0);

        wait_idle();
        push_idle_pct = 78;
        pop_idle_pct  = 15;
        program_registers(8'd255, 16'd0);
        now_ms = $urandom;
        run_wind(350, 1'b0);
        wait_idle();
        program_registers(8'($urandom_range(1, 254)), 16'($urandom_range(1, 65534)));
        run_wind(350, 1'b0);

        wait_idle();
        push_idle_pct = 0;
        pop_idle_pct  = 0;
        program_registers(DEBOUNCE_RESET, GAIN_RESET);
        run_wind(350, 1'b0);

        wait_idle();
        program_registers(8'($urandom), 16'($urandom));
        now_ms = $urandom;
        run_wind(50, 1'b0);

        wait_idle();
        if (tracker.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
